/* hw/rtl/varc_pkg.sv */
// Shared constants, types and codes of the voxel auto-range colorizer.
package varc_pkg;

   // Field widths of the item and result transactions.
   localparam int SAMPLE_WIDTH    = 32;
   localparam int PART_WIDTH      = 32;
   localparam int POT_WIDTH       = 32;
   localparam int PROB_WIDTH      = 2 * PART_WIDTH;
   localparam int SCALE_WIDTH     = 31;
   localparam int COLOR_WIDTH     = 8;

   // Divider lanes work on 64-bit magnitudes and return one color byte.
   localparam int DIV_WIDTH       = 64;
   localparam int DIV_PROD_WIDTH  = DIV_WIDTH + COLOR_WIDTH;
   localparam int DIV_STEP_WIDTH  = $clog2(COLOR_WIDTH);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

   // Configuration port.
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Parts keep only their SAMPLE_WIDTH most significant bits.
   localparam logic [PART_WIDTH-1:0] PART_KEEP_MASK =
      {PART_WIDTH{1'b1}} << (PART_WIDTH - SAMPLE_WIDTH);

   localparam logic [SCALE_WIDTH-1:0] FULL_SCALE_RESET = SCALE_WIDTH'(429497);
   localparam logic [COLOR_WIDTH-1:0] COLOR_FULL = {COLOR_WIDTH{1'b1}};
   localparam logic [COLOR_WIDTH-1:0] COLOR_NONE = '0;

   // Running extreme start values.
   localparam logic [PROB_WIDTH-1:0] PROB_MIN_START = {PROB_WIDTH{1'b1}};
   localparam logic [PROB_WIDTH-1:0] PROB_MAX_START = '0;
   localparam logic [POT_WIDTH-1:0]  POT_MIN_START  = {1'b0, {(POT_WIDTH-1){1'b1}}};
   localparam logic [POT_WIDTH-1:0]  POT_MAX_START  = {1'b1, {(POT_WIDTH-1){1'b0}}};

   typedef enum logic {
      ACTION_MEASURE = 1'b0,
      ACTION_PAINT   = 1'b1
   } varc_action_type;

   typedef enum logic {
      THEME_PROBABILITY = 1'b0,
      THEME_COMPONENTS  = 1'b1
   } varc_theme_type;

   typedef enum logic {
      REG_DISPLAY_THEME = 1'b0,
      REG_FULL_SCALE    = 1'b1
   } varc_reg_type;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      varc_action_type         action;
      logic [PART_WIDTH-1:0]   re;
      logic [PART_WIDTH-1:0]   im;
      logic [POT_WIDTH-1:0]    pot;
      logic                    fixed_cell;
      logic                    last;
      logic [PROB_WIDTH-1:0]   prob;
   } varc_entry_type;

   // Configuration as seen by the back.
   typedef struct packed {
      varc_theme_type          theme;
      logic [SCALE_WIDTH-1:0]  full_scale;
   } varc_cfg_type;

   // Operands of one scaling job: floor(255 * n / d), clamped.
   typedef struct packed {
      logic                    n_pos;
      logic [DIV_WIDTH-1:0]    n_mag;
      logic                    d_pos;
      logic [DIV_WIDTH-1:0]    d_mag;
   } varc_div_req_type;

endpackage

/* hw/rtl/varc_divider.sv */
// Bit-serial scaling lane: one quotient bit of floor(255*n/d) per cycle.
module varc_divider import varc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  varc_div_req_type       req,
   output logic                   busy,
   output logic [COLOR_WIDTH-1:0] quot
);

   localparam logic [DIV_STEP_WIDTH-1:0] LAST_STEP = DIV_STEP_WIDTH'(COLOR_WIDTH - 1);

   logic                      busy_ff, busy_in;
   logic [DIV_STEP_WIDTH-1:0] step_ff;
   logic [DIV_WIDTH-1:0]      rem_ff;
   logic [DIV_WIDTH-1:0]      d_ff;
   logic [COLOR_WIDTH-1:0]    low_ff;
   logic [COLOR_WIDTH-1:0]    quot_ff;

   logic [DIV_PROD_WIDTH-1:0] prod;
   logic [DIV_WIDTH:0]        trial;
   logic [DIV_WIDTH:0]        diff;
   logic                      fits;
   logic                      direct;
   logic [COLOR_WIDTH-1:0]    direct_quot;

   // The numerator 255*n as a shift and a subtract.
   assign prod = {req.n_mag, COLOR_WIDTH'(0)} - {COLOR_WIDTH'(0), req.n_mag};

   // Clamp and zero-divisor rules settle the result without iterating.
   always_comb begin
      direct      = 1'b1;
      direct_quot = COLOR_NONE;
      if (!req.d_pos) begin
         direct_quot = req.n_pos ? COLOR_FULL : COLOR_NONE;
      end else if (!req.n_pos) begin
         direct_quot = COLOR_NONE;
      end else if (req.n_mag >= req.d_mag) begin
         direct_quot = COLOR_FULL;
      end else begin
         direct = 1'b0;
      end
   end

   // One restoring step: shift in the next numerator bit and try the divisor.
   assign trial = {rem_ff, low_ff[COLOR_WIDTH-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = (trial >= {1'b0, d_ff});

   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = !direct;
      end else if (busy_ff && step_ff == LAST_STEP) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= direct ? direct_quot : COLOR_NONE;
         rem_ff  <= prod[DIV_PROD_WIDTH-1:COLOR_WIDTH];
         low_ff  <= prod[COLOR_WIDTH-1:0];
         d_ff    <= req.d_mag;
         step_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         low_ff  <= {low_ff[COLOR_WIDTH-2:0], 1'b0};
         quot_ff <= {quot_ff[COLOR_WIDTH-2:0], fits};
         step_ff <= step_ff + DIV_STEP_WIDTH'(1);
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

/* hw/rtl/varc_front.sv */
// Front part: accepts items, quantizes the parts and computes the probability.
module varc_front import varc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [PART_WIDTH-1:0]  req_real_part,
   input  logic [PART_WIDTH-1:0]  req_imag_part,
   input  logic [POT_WIDTH-1:0]   req_potential,
   input  logic                   req_fixed_cell,
   input  logic                   req_last,
   output logic                   push_valid,
   output varc_entry_type         push_entry,
   input  logic                   queue_full
);

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_SQ_RE = 4'b0010,
      F_SQ_IM = 4'b0100,
      F_PUSH  = 4'b1000
   } varc_front_state_type;

   varc_front_state_type   state_ff, state_in;
   varc_entry_type         item_ff;
   logic [PART_WIDTH-1:0]  re_mag_ff, im_mag_ff;
   logic [PROB_WIDTH-1:0]  prod_ff, acc_ff;

   logic                   accept;
   logic [PART_WIDTH-1:0]  re_q, im_q, re_mag_in, im_mag_in;
   logic [PART_WIDTH-1:0]  mult_op;
   logic [PROB_WIDTH-1:0]  prod_in;

   assign accept    = req_valid && (state_ff == F_IDLE);
   assign req_stall = (state_ff != F_IDLE);

   // Quantize the parts and take their magnitudes.
   assign re_q      = req_real_part & PART_KEEP_MASK;
   assign im_q      = req_imag_part & PART_KEEP_MASK;
   assign re_mag_in = re_q[PART_WIDTH-1] ? (~re_q + PART_WIDTH'(1)) : re_q;
   assign im_mag_in = im_q[PART_WIDTH-1] ? (~im_q + PART_WIDTH'(1)) : im_q;

   // One shared multiplier squares the real part, then the imaginary part.
   assign mult_op = (state_ff == F_SQ_RE) ? re_mag_ff : im_mag_ff;
   assign prod_in = PROB_WIDTH'(mult_op) * PROB_WIDTH'(mult_op);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (accept) state_in = F_SQ_RE;
         F_SQ_RE: state_in = F_SQ_IM;
         F_SQ_IM: state_in = F_PUSH;
         F_PUSH:  if (!queue_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Item payload and the partial squares.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.action     <= varc_action_type'(req_action);
         item_ff.re         <= re_q;
         item_ff.im         <= im_q;
         item_ff.pot        <= req_potential;
         item_ff.fixed_cell <= req_fixed_cell;
         item_ff.last       <= req_last;
         item_ff.prob       <= '0;
         re_mag_ff          <= re_mag_in;
         im_mag_ff          <= im_mag_in;
      end
      if (state_ff == F_SQ_RE) begin
         prod_ff <= prod_in;
      end
      if (state_ff == F_SQ_IM) begin
         acc_ff  <= prod_ff;
         prod_ff <= prod_in;
      end
   end

   // The sum of squares never exceeds 2^63, so it fits without a carry.
   always_comb begin
      push_entry      = item_ff;
      push_entry.prob = acc_ff + prod_ff;
   end

   assign push_valid = (state_ff == F_PUSH);

endmodule

/* hw/rtl/varc_queue.sv */
// Short queue of classified items between the front and the back.
module varc_queue import varc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  varc_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output varc_entry_type head,
   output logic           empty
);

   localparam logic [QUEUE_PTR_WIDTH:0] COUNT_ONE  = (QUEUE_PTR_WIDTH+1)'(1);
   localparam logic [QUEUE_PTR_WIDTH:0] COUNT_FULL = (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH);

   varc_entry_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH:0]     count_ff, count_in;
   logic                         push;

   assign full  = (count_ff == COUNT_FULL);
   assign empty = (count_ff == '0);
   assign push  = push_valid && !full;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The fill count stays within the queue depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_FULL)
      else $error("queue fill count beyond depth");

   // The back never takes an item from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");

   // A push without a pop grows the fill count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + COUNT_ONE))
      else $error("queue fill count out of step with pushes");

endmodule

/* hw/rtl/varc_back.sv */
// Back part: tracks and latches extremes, and paints colors with three scaling lanes.
module varc_back import varc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  varc_cfg_type           cfg,
   input  logic                   empty,
   input  varc_entry_type         head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COLOR_WIDTH-1:0] rsp_red,
   output logic [COLOR_WIDTH-1:0] rsp_green,
   output logic [COLOR_WIDTH-1:0] rsp_blue,
   output logic [COLOR_WIDTH-1:0] rsp_alpha,
   output logic                   rsp_end_of_frame
);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_DIV  = 2'b10
   } varc_back_state_type;

   varc_back_state_type     state_ff, state_in;

   logic [PROB_WIDTH-1:0]   run_prob_min_ff, run_prob_max_ff;
   logic [POT_WIDTH-1:0]    run_pot_min_ff, run_pot_max_ff;
   logic [PROB_WIDTH-1:0]   held_prob_min_ff, held_prob_max_ff;
   logic [POT_WIDTH-1:0]    held_pot_min_ff, held_pot_max_ff;

   logic                    fixed_ff, override_ff, last_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COLOR_WIDTH-1:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic                    eof_ff;

   logic                    measure_go, paint_go, finish;
   logic [PROB_WIDTH-1:0]   prob_min_in, prob_max_in;
   logic [POT_WIDTH-1:0]    pot_min_in, pot_max_in;
   logic                    override;
   logic [POT_WIDTH:0]      pot_diff;
   logic                    prob_above;
   logic [PROB_WIDTH-1:0]   prob_diff;
   varc_div_req_type        red_req, green_req, alpha_req;
   logic                    red_busy, green_busy, alpha_busy;
   logic [COLOR_WIDTH-1:0]  red_q, green_q, alpha_q;
   logic [COLOR_WIDTH-1:0]  red_in, green_in, blue_in, alpha_in;

   assign pop        = (state_ff == B_IDLE) && !empty;
   assign measure_go = pop && (head.action == ACTION_MEASURE);
   assign paint_go   = pop && (head.action == ACTION_PAINT);
   assign finish     = (state_ff == B_DIV) && !red_busy && !green_busy && !alpha_busy &&
                       (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (paint_go) state_in = B_DIV;
         B_DIV:   if (finish) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Running extremes including the current measure item.
   assign prob_min_in = (head.prob < run_prob_min_ff) ? head.prob : run_prob_min_ff;
   assign prob_max_in = (head.prob > run_prob_max_ff) ? head.prob : run_prob_max_ff;
   assign pot_min_in  = ($signed(head.pot) < $signed(run_pot_min_ff)) ? head.pot : run_pot_min_ff;
   assign pot_max_in  = ($signed(head.pot) > $signed(run_pot_max_ff)) ? head.pot : run_pot_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_prob_min_ff  <= PROB_MIN_START;
         run_prob_max_ff  <= PROB_MAX_START;
         run_pot_min_ff   <= POT_MIN_START;
         run_pot_max_ff   <= POT_MAX_START;
         held_prob_min_ff <= '0;
         held_prob_max_ff <= '0;
         held_pot_min_ff  <= '0;
         held_pot_max_ff  <= '0;
      end else if (measure_go) begin
         if (head.last) begin
            held_prob_min_ff <= prob_min_in;
            held_prob_max_ff <= prob_max_in;
            held_pot_min_ff  <= pot_min_in;
            held_pot_max_ff  <= pot_max_in;
            run_prob_min_ff  <= PROB_MIN_START;
            run_prob_max_ff  <= PROB_MAX_START;
            run_pot_min_ff   <= POT_MIN_START;
            run_pot_max_ff   <= POT_MAX_START;
         end else begin
            run_prob_min_ff  <= prob_min_in;
            run_prob_max_ff  <= prob_max_in;
            run_pot_min_ff   <= pot_min_in;
            run_pot_max_ff   <= pot_max_in;
         end
      end
   end

   // The potential takes over the color when it is nonzero, a range is held and the cell is not fixed.
   assign override = ((held_pot_min_ff != '0) || (held_pot_max_ff != '0)) &&
                     (head.pot != '0) && !head.fixed_cell;

   assign pot_diff   = {head.pot[POT_WIDTH-1], head.pot} -
                       {held_pot_min_ff[POT_WIDTH-1], held_pot_min_ff};
   assign prob_above = (head.prob > held_prob_min_ff);
   assign prob_diff  = head.prob - held_prob_min_ff;

   // Scaling jobs: red and green from the parts, alpha from probability or potential.
   always_comb begin
      red_req.n_pos   = !head.re[PART_WIDTH-1] && (head.re != '0);
      red_req.n_mag   = DIV_WIDTH'(head.re);
      red_req.d_pos   = (cfg.full_scale != '0);
      red_req.d_mag   = DIV_WIDTH'(cfg.full_scale);

      green_req.n_pos = !head.im[PART_WIDTH-1] && (head.im != '0);
      green_req.n_mag = DIV_WIDTH'(head.im);
      green_req.d_pos = (cfg.full_scale != '0);
      green_req.d_mag = DIV_WIDTH'(cfg.full_scale);

      if (override) begin
         alpha_req.n_pos = !pot_diff[POT_WIDTH] && (pot_diff != '0);
         alpha_req.n_mag = DIV_WIDTH'(pot_diff[POT_WIDTH-1:0]);
         alpha_req.d_pos = !held_pot_max_ff[POT_WIDTH-1] && (held_pot_max_ff != '0);
         alpha_req.d_mag = DIV_WIDTH'(held_pot_max_ff);
      end else begin
         alpha_req.n_pos = prob_above;
         alpha_req.n_mag = prob_diff;
         alpha_req.d_pos = (held_prob_max_ff != '0);
         alpha_req.d_mag = held_prob_max_ff;
      end
   end

   varc_divider u_red_lane (
      .clock (clock),
      .reset (reset),
      .start (paint_go),
      .req   (red_req),
      .busy  (red_busy),
      .quot  (red_q)
   );

   varc_divider u_green_lane (
      .clock (clock),
      .reset (reset),
      .start (paint_go),
      .req   (green_req),
      .busy  (green_busy),
      .quot  (green_q)
   );

   varc_divider u_alpha_lane (
      .clock (clock),
      .reset (reset),
      .start (paint_go),
      .req   (alpha_req),
      .busy  (alpha_busy),
      .quot  (alpha_q)
   );

   // Remember how the color of the painted item is composed.
   always_ff @(posedge clock) begin
      if (paint_go) begin
         fixed_ff    <= head.fixed_cell;
         override_ff <= override;
         last_ff     <= head.last;
      end
   end

   // Color selection once all lanes are done.
   always_comb begin
      if (fixed_ff) begin
         red_in   = COLOR_NONE;
         green_in = COLOR_NONE;
         blue_in  = COLOR_FULL;
         alpha_in = COLOR_FULL;
      end else if (override_ff) begin
         red_in   = COLOR_FULL;
         green_in = COLOR_NONE;
         blue_in  = COLOR_FULL;
         alpha_in = alpha_q;
      end else if (cfg.theme == THEME_COMPONENTS) begin
         red_in   = red_q;
         green_in = green_q;
         blue_in  = COLOR_NONE;
         alpha_in = alpha_q;
      end else begin
         red_in   = COLOR_FULL;
         green_in = COLOR_FULL;
         blue_in  = COLOR_FULL;
         alpha_in = alpha_q;
      end
   end

   // Output register holds a finished transaction until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
         eof_ff   <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_alpha        = alpha_ff;
   assign rsp_end_of_frame = eof_ff;

   // A new result appears only at the end of a paint.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_DIV))
      else $error("result raised outside of a paint");

endmodule

/* hw/rtl/voxel_auto_range_colorizer_top.sv */
// Top level of the voxel auto-range colorizer with its configuration registers.
//
// Items enter on the req_ channel (valid/stall) and are taken when req_valid
// is high and req_stall is low. A measure item (action 0) updates the running
// probability and potential extremes and gives no result; a measure item
// marked last latches them for the painting pass. A paint item (action 1)
// gives one RGBA result on the rsp_ channel, in item order.
// The front takes a new item only after it has pushed the last one; one
// shared 32x32 multiplier squares the real and then the imaginary part.
// A four-entry queue decouples it from the back. The back retires a measure
// item as it pops it, and a paint item once its three bit-serial scaling
// lanes are done and the output register is free; each lane produces one bit
// of an 8-bit quotient per cycle, or settles without iterating on a clamp.
// A stalled result holds in the output register; the back then waits, the
// queue fills and req_stall rises. Reset clears the queue and the latched
// extremes, restarts the running ones, sets the registers (probability
// theme, full scale 429497) and needs no sweep.
// Registers: display_theme at byte 0, component_full_scale at byte 4.
module voxel_auto_range_colorizer_top import varc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic signed [PART_WIDTH-1:0] req_real_part,
   input  logic signed [PART_WIDTH-1:0] req_imag_part,
   input  logic signed [POT_WIDTH-1:0]  req_potential,
   input  logic                      req_fixed_cell,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [COLOR_WIDTH-1:0]    rsp_red,
   output logic [COLOR_WIDTH-1:0]    rsp_green,
   output logic [COLOR_WIDTH-1:0]    rsp_blue,
   output logic [COLOR_WIDTH-1:0]    rsp_alpha,
   output logic                      rsp_end_of_frame,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   varc_theme_type          theme_ff, theme_in;
   logic [SCALE_WIDTH-1:0]  full_scale_ff, full_scale_in;
   logic                    csr_write;
   varc_reg_type            csr_index;
   varc_cfg_type            cfg;

   logic                    push_valid, queue_full, queue_empty, pop;
   varc_entry_type          push_entry, head;

   // Configuration registers, one per word.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = varc_reg_type'(paddr[2]);

   always_comb begin
      theme_in      = theme_ff;
      full_scale_in = full_scale_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DISPLAY_THEME: theme_in      = varc_theme_type'(pwdata[0]);
            REG_FULL_SCALE:    full_scale_in = pwdata[SCALE_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         theme_ff      <= THEME_PROBABILITY;
         full_scale_ff <= FULL_SCALE_RESET;
      end else begin
         theme_ff      <= theme_in;
         full_scale_ff <= full_scale_in;
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_DISPLAY_THEME: prdata = CSR_DATA_WIDTH'(theme_ff);
         REG_FULL_SCALE:    prdata = CSR_DATA_WIDTH'(full_scale_ff);
      endcase
   end

   assign cfg.theme      = theme_ff;
   assign cfg.full_scale = full_scale_ff;

   varc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_real_part  (req_real_part),
      .req_imag_part  (req_imag_part),
      .req_potential  (req_potential),
      .req_fixed_cell (req_fixed_cell),
      .req_last       (req_last),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .queue_full     (queue_full)
   );

   varc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   varc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .empty            (queue_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

/* verif/tb_voxel_auto_range_colorizer_top.sv */
// Self-checking testbench for the voxel auto-range colorizer top level.
`timescale 1ns / 100ps

module tb_voxel_auto_range_colorizer_top;
   import varc_pkg::*;

   localparam int          ITEM_TARGET  = 2000;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          IDLE_SETTLE  = 32;
   localparam int          DRAIN_CYCLES = 64;
   localparam int          LONG_HOLD    = 400;
   localparam int          PRINT_LIMIT  = 40;
   localparam logic [31:0] KEEP_MASK    = 32'hFFFF_FFFF << (PART_WIDTH - SAMPLE_WIDTH);
   localparam logic [31:0] PART_MIN     = 32'h8000_0000;
   localparam logic [31:0] PART_MAX     = 32'h7FFF_FFFF;

   // One color transaction on the result channel.
   typedef struct packed {
      logic [COLOR_WIDTH-1:0] red;
      logic [COLOR_WIDTH-1:0] green;
      logic [COLOR_WIDTH-1:0] blue;
      logic [COLOR_WIDTH-1:0] alpha;
      logic                   eof;
   } color_t;

   // One voxel transaction on the item channel.
   typedef struct {
      varc_action_type    action;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic signed [31:0] pot;
      logic               fixed_cell;
      logic               last;
   } voxel_t;

   typedef enum bit { ROW_ITEM, ROW_CFG } row_kind_t;

   // One row of the directed table: either a voxel or a register write.
   typedef struct {
      row_kind_t    kind;
      varc_reg_type which;
      logic [31:0]  value;
      voxel_t       item;
      bit           typed;
      color_t       want;
   } stim_row_t;

   // Clock, reset and block ports.
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_action = 1'b0;
   logic signed [PART_WIDTH-1:0] req_real_part = '0;
   logic signed [PART_WIDTH-1:0] req_imag_part = '0;
   logic signed [POT_WIDTH-1:0]  req_potential = '0;
   logic                        req_fixed_cell = 1'b0;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [COLOR_WIDTH-1:0]      rsp_red;
   logic [COLOR_WIDTH-1:0]      rsp_green;
   logic [COLOR_WIDTH-1:0]      rsp_blue;
   logic [COLOR_WIDTH-1:0]      rsp_alpha;
   logic                        rsp_end_of_frame;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]   paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]   pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]   prdata;
   logic                        pready;

   // Predictor copy of the configuration and of the extreme registers.
   varc_theme_type              theme_sel = THEME_PROBABILITY;
   logic [SCALE_WIDTH-1:0]      full_scale_cfg = 31'd429497;
   logic [63:0]                 prob_lo_run = '1;
   logic [63:0]                 prob_hi_run = '0;
   logic signed [31:0]          pot_lo_run = 32'sh7FFF_FFFF;
   logic signed [31:0]          pot_hi_run = 32'sh8000_0000;
   logic [63:0]                 prob_lo_held = '0;
   logic [63:0]                 prob_hi_held = '0;
   logic signed [31:0]          pot_lo_held = '0;
   logic signed [31:0]          pot_hi_held = '0;

   color_t                      expected_colors[$];
   int                          mismatch_count = 0;
   int                          cycle_count = 0;
   int                          items_sent = 0;
   int                          burst_left = 0;
   int                          hold_left = 0;
   int                          mode_left = 0;
   int                          stall_mode = 0;
   bit                          hold_request = 1'b0;

   voxel_auto_range_colorizer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_real_part    (req_real_part),
      .req_imag_part    (req_imag_part),
      .req_potential    (req_potential),
      .req_fixed_cell   (req_fixed_cell),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_end_of_frame (rsp_end_of_frame),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Prints one line per mismatch, up to a limit, and counts all of them.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_LIMIT)
         $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                  cycle_count);
      mismatch_count++;
   endtask

   // floor(255 * num / den), clamped; a divisor at or below zero saturates on sign.
   function automatic logic [7:0] scale_ratio(input longint num, input longint den);
      if (den <= 0)
         return (num > 0) ? COLOR_FULL : COLOR_NONE;
      if (num <= 0)
         return COLOR_NONE;
      if (num >= den)
         return COLOR_FULL;
      return 8'((num * 255) / den);
   endfunction

   // Opacity from the probability against the latched probability range.
   function automatic logic [7:0] prob_opacity(input logic [63:0] prob);
      logic [63:0] excess;
      logic [71:0] quotient;
      excess = (prob > prob_lo_held) ? prob - prob_lo_held : 64'd0;
      if (prob_hi_held == 64'd0)
         return (excess != 64'd0) ? COLOR_FULL : COLOR_NONE;
      if (excess >= prob_hi_held)
         return COLOR_FULL;
      quotient = ({8'd0, excess} * 72'd255) / {8'd0, prob_hi_held};
      return quotient[7:0];
   endfunction

   // Applies one voxel to the predicted state and returns the color it causes.
   task automatic colorize_voxel(input voxel_t v, output bit produces, output color_t c);
      logic signed [31:0] re_q;
      logic signed [31:0] im_q;
      logic [63:0]        re_mag;
      logic [63:0]        im_mag;
      logic [63:0]        prob;
      re_q = v.re & KEEP_MASK;
      im_q = v.im & KEEP_MASK;
      re_mag = (re_q < 0) ? 64'(-longint'(re_q)) : 64'(longint'(re_q));
      im_mag = (im_q < 0) ? 64'(-longint'(im_q)) : 64'(longint'(im_q));
      prob = re_mag * re_mag + im_mag * im_mag;
      c = '0;
      c.eof = v.last;
      produces = 1'b0;
      if (v.action == ACTION_MEASURE) begin
         // Track the running extremes; the final voxel latches and restarts them.
         if (prob < prob_lo_run) prob_lo_run = prob;
         if (prob > prob_hi_run) prob_hi_run = prob;
         if (v.pot < pot_lo_run) pot_lo_run = v.pot;
         if (v.pot > pot_hi_run) pot_hi_run = v.pot;
         if (v.last) begin
            prob_lo_held = prob_lo_run;
            prob_hi_held = prob_hi_run;
            pot_lo_held = pot_lo_run;
            pot_hi_held = pot_hi_run;
            prob_lo_run = '1;
            prob_hi_run = '0;
            pot_lo_run = 32'sh7FFF_FFFF;
            pot_hi_run = 32'sh8000_0000;
         end
      end else begin
         produces = 1'b1;
         if (v.fixed_cell) begin
            c.red = COLOR_NONE;
            c.green = COLOR_NONE;
            c.blue = COLOR_FULL;
            c.alpha = COLOR_FULL;
         end else begin
            if (theme_sel == THEME_COMPONENTS) begin
               c.red = scale_ratio(longint'(re_q), longint'(full_scale_cfg));
               c.green = scale_ratio(longint'(im_q), longint'(full_scale_cfg));
               c.blue = COLOR_NONE;
            end else begin
               c.red = COLOR_FULL;
               c.green = COLOR_FULL;
               c.blue = COLOR_FULL;
            end
            c.alpha = prob_opacity(prob);
            // A nonzero potential overrides with magenta once a potential range exists.
            if ((pot_lo_held != 0 || pot_hi_held != 0) && v.pot != 0) begin
               c.red = COLOR_FULL;
               c.green = COLOR_NONE;
               c.blue = COLOR_FULL;
               c.alpha = scale_ratio(longint'(v.pot) - longint'(pot_lo_held),
                                     longint'(pot_hi_held));
            end
         end
      end
   endtask

   // Offers one voxel in bursts with random gaps and records its prediction.
   task automatic send_voxel(input voxel_t v, input bit typed, input color_t typed_color);
      int     gap;
      bit     produces;
      color_t c;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_action <= v.action;
      req_real_part <= v.re;
      req_imag_part <= v.im;
      req_potential <= v.pot;
      req_fixed_cell <= v.fixed_cell;
      req_last <= v.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
      colorize_voxel(v, produces, c);
      if (produces)
         expected_colors.insert(expected_colors.size(), typed ? typed_color : c);
   endtask

   // Stops offering voxels until every color has come and the back has drained.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Writes one register, then reads it back and compares.
   task automatic csr_write_check(input varc_reg_type which, input logic [31:0] value);
      logic [31:0] want;
      want = (which == REG_DISPLAY_THEME) ? {31'd0, value[0]} : {1'b0, value[30:0]};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_WIDTH'(4 * int'(which));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (which == REG_DISPLAY_THEME)
         theme_sel = varc_theme_type'(value[0]);
      else
         full_scale_cfg = value[30:0];
      // Read back from the same address.
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want)
         report_mismatch("register readback", prdata, want);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_t item_row(input varc_action_type act, input logic [31:0] re,
                                          input logic [31:0] im, input logic [31:0] pot,
                                          input logic fx, input logic lst);
      stim_row_t row;
      row.kind = ROW_ITEM;
      row.which = REG_DISPLAY_THEME;
      row.value = '0;
      row.item.action = act;
      row.item.re = re;
      row.item.im = im;
      row.item.pot = pot;
      row.item.fixed_cell = fx;
      row.item.last = lst;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_t typed_row(input varc_action_type act, input logic [31:0] re,
                                           input logic [31:0] im, input logic [31:0] pot,
                                           input logic fx, input logic lst,
                                           input logic [7:0] red, input logic [7:0] green,
                                           input logic [7:0] blue, input logic [7:0] alpha);
      stim_row_t row;
      row = item_row(act, re, im, pot, fx, lst);
      row.typed = 1'b1;
      row.want = {red, green, blue, alpha, lst};
      return row;
   endfunction

   function automatic stim_row_t cfg_row(input varc_reg_type which, input logic [31:0] value);
      stim_row_t row;
      row = item_row(ACTION_MEASURE, '0, '0, '0, 1'b0, 1'b0);
      row.kind = ROW_CFG;
      row.which = which;
      row.value = value;
      return row;
   endfunction

   // Part values spread over extremes, small values, the full-scale region and wide values.
   function automatic logic [31:0] rand_part();
      logic [31:0] mag;
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'(int'($urandom_range(0, 4000)) - 2000);
         2: begin
            case ($urandom_range(0, 4))
               0: return PART_MIN;
               1: return PART_MAX;
               2: return 32'd0;
               3: return 32'hFFFF_FFFF;
               default: return 32'd1;
            endcase
         end
         3: mag = $urandom_range(0, 32'(full_scale_cfg) * 2);
         default: mag = $urandom() >> $urandom_range(0, 31);
      endcase
      return ($urandom_range(0, 1) == 1) ? -mag : mag;
   endfunction

   function automatic logic [31:0] rand_potential();
      case ($urandom_range(0, 5))
         0, 1: return 32'd0;
         2: return $urandom();
         3: return 32'(int'($urandom_range(0, 200000)) - 100000);
         4: return ($urandom_range(0, 1) == 1) ? PART_MIN : PART_MAX;
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   // A well-formed frame: a measure pass ending in last, then a paint pass ending in last.
   task automatic run_random_frame();
      int     n_meas;
      int     n_paint;
      bit     quiet_pot;
      voxel_t v;
      quiet_pot = ($urandom_range(0, 3) == 0);
      n_meas = $urandom_range(1, 20);
      for (int i = 0; i < n_meas; i++) begin
         v.action = ACTION_MEASURE;
         v.re = rand_part();
         v.im = rand_part();
         v.pot = quiet_pot ? 32'd0 : rand_potential();
         v.fixed_cell = $urandom_range(0, 1);
         v.last = (i == n_meas - 1);
         send_voxel(v, 1'b0, '0);
      end
      n_paint = $urandom_range(1, 20);
      for (int i = 0; i < n_paint; i++) begin
         v.action = ACTION_PAINT;
         v.re = rand_part();
         v.im = rand_part();
         v.pot = rand_potential();
         v.fixed_cell = ($urandom_range(0, 7) == 0);
         v.last = (i == n_paint - 1);
         send_voxel(v, 1'b0, '0);
      end
   endtask

   // Broken sequences: random actions with last set anywhere.
   task automatic run_noise();
      int     n;
      voxel_t v;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         v.action = varc_action_type'($urandom_range(0, 1));
         v.re = rand_part();
         v.im = rand_part();
         v.pot = rand_potential();
         v.fixed_cell = $urandom_range(0, 1);
         v.last = ($urandom_range(0, 3) == 0);
         send_voxel(v, 1'b0, '0);
      end
   endtask

   // New theme and full scale, written while the block is idle.
   task automatic reconfigure();
      logic [31:0] scale;
      case ($urandom_range(0, 4))
         0: scale = 32'd1;
         1: scale = 32'h7FFF_FFFF;
         2: scale = 32'd429497;
         3: scale = $urandom_range(1, 32'h7FFF_FFFF);
         default: scale = $urandom_range(1, 2000000);
      endcase
      wait_idle();
      csr_write_check(REG_DISPLAY_THEME, 32'($urandom_range(0, 1)));
      csr_write_check(REG_FULL_SCALE, scale);
   endtask

   // Result side: check each accepted color, then pick the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            report_mismatch("color with nothing expected", rsp_red, 0);
         end else begin
            if (rsp_red !== expected_colors[0].red)
               report_mismatch("red", rsp_red, expected_colors[0].red);
            if (rsp_green !== expected_colors[0].green)
               report_mismatch("green", rsp_green, expected_colors[0].green);
            if (rsp_blue !== expected_colors[0].blue)
               report_mismatch("blue", rsp_blue, expected_colors[0].blue);
            if (rsp_alpha !== expected_colors[0].alpha)
               report_mismatch("alpha", rsp_alpha, expected_colors[0].alpha);
            if (rsp_end_of_frame !== expected_colors[0].eof)
               report_mismatch("end_of_frame", rsp_end_of_frame, expected_colors[0].eof);
            void'(expected_colors.pop_front());
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 7) == 0);
            2: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Stimulus: reset, the directed table, the random frames, then the drain.
   initial begin
      stim_row_t rows[$];
      int        holds_done;
      holds_done = 0;

      // Reset state: probability theme, no latched range yet.
      rows.insert(rows.size(), typed_row(ACTION_PAINT, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                                         8'd255, 8'd255, 8'd255, 8'd0));
      rows.insert(rows.size(), typed_row(ACTION_PAINT, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0,
                                         8'd255, 8'd255, 8'd255, 8'd255));
      rows.insert(rows.size(), typed_row(ACTION_PAINT, PART_MAX, PART_MIN, 32'd123, 1'b1,
                                         1'b0, 8'd0, 8'd0, 8'd255, 8'd255));
      rows.insert(rows.size(), typed_row(ACTION_PAINT, 32'd0, 32'd0, PART_MAX, 1'b0, 1'b0,
                                         8'd255, 8'd255, 8'd255, 8'd0));
      rows.insert(rows.size(), typed_row(ACTION_PAINT, PART_MIN, PART_MAX, PART_MIN, 1'b0,
                                         1'b1, 8'd255, 8'd255, 8'd255, 8'd255));
      // Full range measure pass, the fixed flag is ignored on the final voxel.
      rows.insert(rows.size(), item_row(ACTION_MEASURE, PART_MIN, PART_MIN, PART_MIN,
                                        1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_MEASURE, 32'd0, 32'd0, PART_MAX, 1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_MEASURE, PART_MAX, PART_MIN, 32'd0,
                                        1'b1, 1'b1));
      rows.insert(rows.size(), item_row(ACTION_PAINT, PART_MAX, PART_MAX, 32'd0, 1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_PAINT, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_PAINT, PART_MIN, PART_MIN, 32'hFFFF_FFFF,
                                        1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_PAINT, 32'd12345, -32'd999, 32'd0,
                                        1'b0, 1'b1));
      // Components theme at the smallest and largest full scale.
      rows.insert(rows.size(), cfg_row(REG_DISPLAY_THEME, 32'(THEME_COMPONENTS)));
      rows.insert(rows.size(), cfg_row(REG_FULL_SCALE, 32'd1));
      rows.insert(rows.size(), item_row(ACTION_PAINT, 32'd1, 32'hFFFF_FFFF, 32'd0,
                                        1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_PAINT, PART_MIN, PART_MAX, 32'd0, 1'b0, 1'b0));
      rows.insert(rows.size(), cfg_row(REG_FULL_SCALE, 32'h7FFF_FFFF));
      rows.insert(rows.size(), item_row(ACTION_PAINT, PART_MAX, PART_MIN, 32'd0, 1'b0, 1'b0));
      // Negative potential maximum gives a divisor below zero.
      rows.insert(rows.size(), item_row(ACTION_MEASURE, 32'd5, 32'd5, -32'd100, 1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_MEASURE, -32'd3, 32'd2, -32'd7, 1'b0, 1'b1));
      rows.insert(rows.size(), item_row(ACTION_PAINT, 32'd40, 32'd0, 32'd50, 1'b0, 1'b0));
      rows.insert(rows.size(), item_row(ACTION_PAINT, 32'd40, 32'd0, -32'd200, 1'b0, 1'b0));
      // A one-voxel pass with zero potential turns the override off again.
      rows.insert(rows.size(), item_row(ACTION_MEASURE, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1));
      rows.insert(rows.size(), item_row(ACTION_PAINT, 32'd100, 32'd0, 32'd9, 1'b0, 1'b0));
      rows.insert(rows.size(), cfg_row(REG_DISPLAY_THEME, 32'(THEME_PROBABILITY)));
      rows.insert(rows.size(), cfg_row(REG_FULL_SCALE, 32'd429497));
      rows.insert(rows.size(), item_row(ACTION_PAINT, 32'd7000, -32'd7000, 32'd0,
                                        1'b0, 1'b1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CFG) begin
            wait_idle();
            csr_write_check(rows[i].which, rows[i].value);
         end else begin
            send_voxel(rows[i].item, rows[i].typed, rows[i].want);
         end
      end

      // Random frames with some noise, reconfiguration and long receiver hold-offs.
      while (items_sent < ITEM_TARGET) begin
         if ((holds_done == 0 && items_sent >= 700) ||
             (holds_done == 1 && items_sent >= 1500)) begin
            hold_request = 1'b1;
            holds_done++;
         end
         case ($urandom_range(0, 9))
            0: run_noise();
            1: reconfigure();
            default: run_random_frame();
         endcase
      end

      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
